// ----- sv/word_hash_bucket_index_assert.svh -----
// Assertion macros for the word hash bucket index modules, used by the remainder unit.
`ifndef WORD_HASH_BUCKET_INDEX_ASSERT_SVH
`define WORD_HASH_BUCKET_INDEX_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define WHB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word hash bucket index: check failed");

// Checks that cons holds in the cycle after ante.
`define WHB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word hash bucket index: check failed");

`endif

// ----- sv/whb_pkg.sv -----
`default_nettype none

package whb_pkg;

    localparam int HASH_WIDTH   = 64;
    localparam int MAX_WORD_LEN = 50;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 6;
    localparam int SIZE_W       = 25;
    localparam int BUCKET_W     = 24;
    localparam int FIFO_DEPTH   = 2;
    localparam int CNT_W        = $clog2(HASH_WIDTH);

    localparam logic [HASH_WIDTH-1:0] HASH_SEED = HASH_WIDTH'(199);
    localparam logic [LEN_W-1:0]      LEN_SAT   = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0]      LEN_LIMIT = LEN_W'(MAX_WORD_LEN);
    localparam logic [SIZE_W-1:0]     SIZE_MAX   = SIZE_W'(16777216);
    localparam logic [SIZE_W-1:0]     SIZE_RESET = SIZE_W'(1024);

    // One finished word as it passes from the front to the remainder unit.
    typedef struct packed {
        logic                  too_long;
        logic [HASH_WIDTH-1:0] hash;
    } word_t;

    // Maps the register value onto a usable bucket count.
    function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] raw);
        logic [SIZE_W-1:0] res;
        if (raw == '0)
            res = SIZE_W'(1);
        else if (raw > SIZE_MAX)
            res = SIZE_MAX;
        else
            res = raw;
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/word_hash_bucket_index.sv -----
// Hashes a word arriving one byte per push (djb2 style, seed 199, hash*33+byte over
// 64 bits) and, at the zero byte that ends it, gives one word: the hash modulo the
// table size, or too_long with bucket 0 for words of more than 50 bytes. The front
// takes one byte per cycle while the two-word queue behind it has room. The remainder
// is worked out one hash bit per cycle: a word is taken from the queue and loaded, the
// division steps through all 64 hash bits, and the result is then shown; a too_long
// word skips the division. A finished result waits on the output until popped, and
// the front keeps taking bytes meanwhile. Write table_size only while idle.
`default_nettype none

module word_hash_bucket_index (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [whb_pkg::BYTE_W-1:0]    char_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [whb_pkg::BUCKET_W-1:0]       bucket_index,
    output logic                               too_long,
    input  wire logic                          table_size_we,
    input  wire logic [whb_pkg::SIZE_W-1:0]    table_size_wdata
);

    logic           q_push, q_full, q_pop, q_empty;
    whb_pkg::word_t q_wdata, q_rdata;

    whb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_byte (char_byte),
        .word_push (q_push),
        .word_data (q_wdata),
        .word_full (q_full)
    );

    whb_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    whb_mod u_mod (
        .clk              (clk),
        .rst_n            (rst_n),
        .table_size_we    (table_size_we),
        .table_size_wdata (table_size_wdata),
        .word_empty       (q_empty),
        .word_data        (q_rdata),
        .word_pop         (q_pop),
        .empty            (empty),
        .pop              (pop),
        .bucket_index     (bucket_index),
        .too_long         (too_long)
    );

endmodule

`default_nettype wire

// ----- sv/whb_front.sv -----
`default_nettype none

module whb_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [whb_pkg::BYTE_W-1:0]   char_byte,
    output logic                              word_push,
    output whb_pkg::word_t                    word_data,
    input  wire logic                         word_full
);

    logic [whb_pkg::HASH_WIDTH-1:0] hash_reg, hash_next;
    logic [whb_pkg::LEN_W-1:0]      len_reg, len_next;
    logic                           accept;
    logic                           is_end;

    assign full   = word_full;
    assign accept = push && !word_full;
    assign is_end = (char_byte == '0);

    assign word_push          = accept && is_end;
    assign word_data.too_long = (len_reg > whb_pkg::LEN_LIMIT);
    assign word_data.hash     = hash_reg;

    always_comb
    begin
        hash_next = hash_reg;
        len_next  = len_reg;
        if (accept) begin
            if (is_end) begin
                hash_next = whb_pkg::HASH_SEED;
                len_next  = '0;
            end else begin
                // Multiply by 33 as a shift by five plus the original value.
                hash_next = hash_reg + {hash_reg[whb_pkg::HASH_WIDTH-6:0], 5'b0}
                          + whb_pkg::HASH_WIDTH'(char_byte);
                if (len_reg != whb_pkg::LEN_SAT)
                    len_next = len_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hash_reg <= whb_pkg::HASH_SEED;
            len_reg  <= '0;
        end else begin
            hash_reg <= hash_next;
            len_reg  <= len_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/whb_fifo.sv -----
`default_nettype none

module whb_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  whb_pkg::word_t      wdata,
    output logic                full,
    input  wire logic           pop,
    output whb_pkg::word_t      rdata,
    output logic                empty
);

    localparam int PTR_W = (whb_pkg::FIFO_DEPTH > 1) ? $clog2(whb_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(whb_pkg::FIFO_DEPTH + 1);

    whb_pkg::word_t   mem_reg [whb_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(whb_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(whb_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(whb_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// ----- sv/whb_mod.sv -----
`default_nettype none

module whb_mod (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          table_size_we,
    input  wire logic [whb_pkg::SIZE_W-1:0]    table_size_wdata,
    input  wire logic                          word_empty,
    input  whb_pkg::word_t                     word_data,
    output logic                               word_pop,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [whb_pkg::BUCKET_W-1:0]       bucket_index,
    output logic                               too_long
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                          state_reg, state_next;
    logic [whb_pkg::SIZE_W-1:0]      cfg_reg, cfg_next;
    logic [whb_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic [whb_pkg::SIZE_W-1:0]      rem_reg, rem_next;
    logic [whb_pkg::HASH_WIDTH-1:0]  div_reg, div_next;
    logic [whb_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [whb_pkg::BUCKET_W-1:0]    bucket_reg, bucket_next;
    logic                            long_reg, long_next;
    logic [whb_pkg::SIZE_W:0]        trial;
    logic [whb_pkg::SIZE_W:0]        diff;
    logic [whb_pkg::SIZE_W-1:0]      rem_step;

    // Restoring division, one dividend bit per cycle, most significant first.
    // The remainder stays below the size, so one extra bit covers the shift.
    assign trial    = {rem_reg, div_reg[whb_pkg::HASH_WIDTH-1]};
    assign diff     = trial - {1'b0, size_reg};
    assign rem_step = diff[whb_pkg::SIZE_W] ? trial[whb_pkg::SIZE_W-1:0]
                                            : diff[whb_pkg::SIZE_W-1:0];

    assign word_pop     = (state_reg == ST_IDLE) && !word_empty;
    assign empty        = (state_reg != ST_DONE);
    assign bucket_index = bucket_reg;
    assign too_long     = long_reg;

    always_comb
    begin
        state_next  = state_reg;
        cfg_next    = table_size_we ? table_size_wdata : cfg_reg;
        size_next   = size_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        bucket_next = bucket_reg;
        long_next   = long_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!word_empty) begin
                    if (word_data.too_long) begin
                        bucket_next = '0;
                        long_next   = 1'b1;
                        state_next  = ST_DONE;
                    end else begin
                        size_next  = whb_pkg::effective_size(cfg_reg);
                        rem_next   = '0;
                        div_next   = word_data.hash;
                        cnt_next   = whb_pkg::CNT_W'(whb_pkg::HASH_WIDTH - 1);
                        long_next  = 1'b0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                rem_next = rem_step;
                div_next = {div_reg[whb_pkg::HASH_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    bucket_next = rem_step[whb_pkg::BUCKET_W-1:0];
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (pop)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            cfg_reg    <= whb_pkg::SIZE_RESET;
            size_reg   <= whb_pkg::SIZE_RESET;
            rem_reg    <= '0;
            div_reg    <= '0;
            cnt_reg    <= '0;
            bucket_reg <= '0;
            long_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cfg_reg    <= cfg_next;
            size_reg   <= size_next;
            rem_reg    <= rem_next;
            div_reg    <= div_next;
            cnt_reg    <= cnt_next;
            bucket_reg <= bucket_next;
            long_reg   <= long_next;
        end
    end

`include "word_hash_bucket_index_assert.svh"

    `WHB_ASSERT_NOW(a_rem_below_size, state_reg == ST_RUN, rem_reg < size_reg)
    `WHB_ASSERT_NOW(a_long_gives_zero, state_reg == ST_DONE && long_reg, bucket_reg == '0)
    `WHB_ASSERT_NEXT(a_last_step_done, state_reg == ST_RUN && cnt_reg == '0, state_reg == ST_DONE)
    `WHB_ASSERT_NOW(a_size_in_range, state_reg == ST_RUN, size_reg != '0 && size_reg <= whb_pkg::SIZE_MAX)

endmodule

`default_nettype wire

// ----- dv/word_hash_bucket_index_test.sv -----
module word_hash_bucket_index_test;
    timeunit 1ns;
    timeprecision 1ps;

    import whb_pkg::*;

    localparam int unsigned ITEM_TARGET   = 900;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES  = 150;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam logic [BYTE_W-1:0] END_OF_WORD = 8'h00;

    typedef struct packed {
        logic                too_long;
        logic [BUCKET_W-1:0] bucket;
    } bucket_result_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [BYTE_W-1:0]   char_byte;
    logic                empty;
    logic                pop;
    logic [BUCKET_W-1:0] bucket_index;
    logic                too_long;
    logic                table_size_we;
    logic [SIZE_W-1:0]   table_size_wdata;

    // Predictor state, kept in step with every accepted byte and register write.
    logic [HASH_WIDTH-1:0] word_hash;
    logic [LEN_W-1:0]      word_len;
    logic [SIZE_W-1:0]     table_size_reg;
    bucket_result_t        pending_buckets[$];

    bit          sender_calm;
    bit          sink_calm;
    logic        hold_sink = 1'b0;
    int unsigned bytes_sent;
    int unsigned words_sent;
    int unsigned long_words;
    int unsigned config_writes;
    int unsigned full_stalls;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned cycle_count;

    word_hash_bucket_index u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .char_byte        (char_byte),
        .empty            (empty),
        .pop              (pop),
        .bucket_index     (bucket_index),
        .too_long         (too_long),
        .table_size_we    (table_size_we),
        .table_size_wdata (table_size_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [HASH_WIDTH-1:0] bucket_count(input logic [SIZE_W-1:0] raw);
        if (raw == '0)
            return 64'd1;
        return (raw > 25'd16777216) ? 64'd16777216 : 64'(raw);
    endfunction

    function automatic void hash_in_byte(input logic [BYTE_W-1:0] b);
        bucket_result_t expected;
        bytes_sent++;
        if (b != END_OF_WORD)
        begin
            word_hash = word_hash * 64'd33 + 64'(b);
            if (word_len != LEN_SAT)
                word_len++;
            return;
        end
        if (word_len > LEN_W'(MAX_WORD_LEN))
        begin
            expected.too_long = 1'b1;
            expected.bucket   = '0;
            long_words++;
        end
        else
        begin
            expected.too_long = 1'b0;
            expected.bucket   = BUCKET_W'(word_hash % bucket_count(table_size_reg));
        end
        pending_buckets.push_back(expected);
        words_sent++;
        word_hash = HASH_SEED;
        word_len  = '0;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_char();
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return 8'hFF;
        if (roll == 1)
            return 8'h01;
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    function automatic int unsigned random_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return $urandom_range(56, 72);
        if (roll < 15)
            return $urandom_range(46, 55);
        return $urandom_range(0, 10);
    endfunction

    // Push stays high after an acceptance, so a gap-free next byte goes out at
    // once; whoever stops sending lowers it in that same step.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        char_byte <= b;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
            full_stalls++;
        end
        hash_in_byte(b);
    endtask

    task automatic send_word(input int unsigned len, input bit calm);
        sender_calm = calm;
        for (int i = 0; i < len; i++)
            send_byte(pick_char());
        send_byte(END_OF_WORD);
    endtask

    // The remainder unit is idle once the last expected result has been popped;
    // the write still waits SETTLE_CYCLES more before it goes in.
    task automatic write_table_size(input logic [SIZE_W-1:0] value);
        push <= 1'b0;
        while (pending_buckets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        table_size_we    <= 1'b1;
        table_size_wdata <= value;
        @(posedge clk);
        table_size_reg = value;
        config_writes++;
        table_size_we <= 1'b0;
    endtask

    task automatic test_directed_words();
        sender_calm = 1'b0;
        // An empty word straight after reset gives the seed modulo 1024.
        send_byte(END_OF_WORD);
        send_byte(END_OF_WORD);
        send_byte(8'hFF);
        send_byte(END_OF_WORD);
        send_byte(8'h01);
        send_byte(END_OF_WORD);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(END_OF_WORD);
    endtask

    task automatic test_long_words();
        write_table_size(25'd1000003);
        // Exactly at the limit, one past it, and long enough to saturate the count.
        send_word(MAX_WORD_LEN, 1'b0);
        send_word(MAX_WORD_LEN + 1, 1'b1);
        send_word(63, 1'b0);
        send_word(70, 1'b0);
    endtask

    task automatic test_table_sizes();
        logic [SIZE_W-1:0] sizes[9];
        sizes = '{25'd1, 25'd0, 25'd16777216, 25'h1FFFFFF, 25'd16777215,
                  25'd16777217, 25'd33, 25'd2, 25'd0};
        sizes[8] = SIZE_W'($urandom_range(3, 16777216));
        foreach (sizes[i])
        begin
            write_table_size(sizes[i]);
            repeat (4) send_word($urandom_range(0, 8), $urandom_range(0, 3) == 0);
        end
    endtask

    // The sink holds off while short words arrive back to back, so the queue
    // fills and full must hold the input off.
    task automatic test_backpressure();
        write_table_size(25'd7);
        fork
            begin
                hold_sink <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_sink <= 1'b0;
            end
            begin
                repeat (30) send_word($urandom_range(0, 2), 1'b1);
            end
        join
    endtask

    // Random words top the run up to the byte target.
    task automatic test_random_words();
        int unsigned words;
        words = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (words % 40 == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_table_size(SIZE_W'(1) << $urandom_range(0, 24));
                else
                    write_table_size(SIZE_W'($urandom_range(1, 5000)));
            end
            send_word(random_length(), $urandom_range(0, 3) == 0);
            words++;
        end
    endtask

    // Checks each result word against the oldest expectation.
    initial
    begin
        bucket_result_t want;
        int unsigned    stall_left;
        stall_left = 0;
        sink_calm  = 1'b0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_buckets.size() == 0)
                begin
                    $display("%0t: result with nothing expected, bucket_index %0d too_long %0b",
                             $time, bucket_index, too_long);
                    mismatches++;
                end
                else
                begin
                    want = pending_buckets.pop_front();
                    if (bucket_index !== want.bucket)
                    begin
                        $display("%0t: bucket_index expected %0d actual %0d",
                                 $time, want.bucket, bucket_index);
                        mismatches++;
                    end
                    if (too_long !== want.too_long)
                    begin
                        $display("%0t: too_long expected %0b actual %0b",
                                 $time, want.too_long, too_long);
                        mismatches++;
                    end
                end
                results_checked++;
                if (results_checked % 16 == 0)
                    sink_calm = ($urandom_range(0, 2) == 0);
                stall_left = sink_calm ? 0 : $urandom_range(0, 12);
            end
            else if (stall_left > 0)
                stall_left--;
            pop <= (stall_left == 0) && !hold_sink;
        end
    end

    initial
    begin
        push             <= 1'b0;
        char_byte        <= '0;
        table_size_we    <= 1'b0;
        table_size_wdata <= '0;
        rst_n            <= 1'b0;
        word_hash      = HASH_SEED;
        word_len       = '0;
        table_size_reg = SIZE_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_words();
        test_long_words();
        test_table_sizes();
        test_backpressure();
        test_random_words();

        push <= 1'b0;
        while (pending_buckets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d bytes in %0d words, %0d of them over length, %0d table size writes",
                 bytes_sent, words_sent, long_words, config_writes);
        $display("summary: %0d results checked, input held off on %0d cycles, %0d mismatches",
                 results_checked, full_stalls, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/whb_pkg.sv
sv/whb_front.sv
sv/whb_fifo.sv
sv/whb_mod.sv
sv/word_hash_bucket_index.sv
dv/word_hash_bucket_index_test.sv
